// ===== hw/rtl/ctd_pkg.sv =====
// shared constants, phase type and helpers for the chunked transfer decoder
package ctd_pkg;

   localparam int unsigned MAX_SIZE_CHARS_DEF = 15;
   localparam int unsigned LENGTH_BITS_DEF    = 24;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned TOTAL_W   = 24;
   localparam int unsigned SIZE_W    = 32;
   localparam int unsigned CHAR_CNT_W = 4;
   localparam int unsigned DIGIT_W   = 4;

   localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;

   typedef enum logic [2:0] {
      PH_SEEK = 3'd0,
      PH_SIZE = 3'd1,
      PH_SKIP = 3'd2,
      PH_EOL  = 3'd3,
      PH_DATA = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   typedef struct packed {
      logic                is_hex;
      logic [DIGIT_W-1:0]  value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [BYTE_W-1:0] c);
      hex_digit_type d;
      d.is_hex = 1'b1;
      d.value  = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = DIGIT_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = DIGIT_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = DIGIT_W'(c - 8'h37);
      end else begin
         d.is_hex = 1'b0;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/ctd_if.sv =====
// request and response channel interfaces of the chunked transfer decoder
interface ctd_req_if;
   logic                          valid;
   logic                          ready;
   logic [ctd_pkg::BYTE_W-1:0]    in_byte;
   logic                          final_byte;

   modport source (output valid, output in_byte, output final_byte, input ready);
   modport sink   (input valid, input in_byte, input final_byte, output ready);
   modport mon    (input valid, input in_byte, input final_byte, input ready);
endinterface

interface ctd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ctd_pkg::BYTE_W-1:0]    out_byte;
   logic                          byte_valid;
   logic                          end_of_stream;
   logic [ctd_pkg::TOTAL_W-1:0]   total_length;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_stream, output total_length, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_stream, input total_length, output ready);
   modport mon    (input valid, input out_byte, input byte_valid,
                   input end_of_stream, input total_length, input ready);
endinterface

// ===== hw/rtl/chunked_transfer_decoder.sv =====
// chunked transfer decoder: chunk-encoded body in, payload bytes out
//
// req_chan carries one raw byte of the encoded body per transaction, with
// final_byte marking the last byte of a body. rsp_chan carries at most one
// transaction per request: a payload byte (byte_valid), or the end-of-body
// report (end_of_stream with total_length), or both at once. Size lines,
// chunk separators and bytes after the terminating chunk produce nothing.
// A response appears in the cycle after its request; one byte is taken every
// clock, limited only by the single output register. req_chan.ready stays
// high while the output register is empty or being drained in the same
// cycle, so a stalled receiver holds the pending response and stops input
// after one held transaction. Synchronous reset returns the parser to the
// seek state, clears the length count and empties the output register.
// After the final byte of a body all parser state returns to its reset
// values, so the next byte starts a new body.
module chunked_transfer_decoder #(
   parameter int unsigned MAX_SIZE_CHARS = ctd_pkg::MAX_SIZE_CHARS_DEF,
   parameter int unsigned LENGTH_BITS    = ctd_pkg::LENGTH_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ctd_req_if.sink   req_chan,
   ctd_rsp_if.source rsp_chan
);

   localparam int unsigned WIDE_W = (LENGTH_BITS > ctd_pkg::TOTAL_W) ?
                                    LENGTH_BITS : ctd_pkg::TOTAL_W;
   localparam logic [ctd_pkg::CHAR_CNT_W-1:0] MAX_CHARS =
      ctd_pkg::CHAR_CNT_W'(MAX_SIZE_CHARS);

   ctd_pkg::phase_type                 phase_ff, phase_in;
   logic [ctd_pkg::CHAR_CNT_W-1:0]     char_cnt_ff, char_cnt_in;
   logic                               hex_stop_ff, hex_stop_in;
   logic [ctd_pkg::SIZE_W-1:0]         size_ff, size_in;
   logic [LENGTH_BITS-1:0]             length_ff, length_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ctd_pkg::BYTE_W-1:0]         out_byte_ff, out_byte_in;
   logic                               byte_valid_ff, byte_valid_in;
   logic                               eos_ff, eos_in;
   logic [ctd_pkg::TOTAL_W-1:0]        total_ff, total_in;

   logic                               accept;
   logic [ctd_pkg::BYTE_W-1:0]         b;
   logic                               is_cr, is_lf, is_nul, is_ws, is_semi;
   logic                               start_line, do_size, collect, tail;
   logic                               line_end, size_ok, take;
   logic [ctd_pkg::CHAR_CNT_W-1:0]     base_cnt;
   logic                               base_stop;
   logic [ctd_pkg::SIZE_W-1:0]         base_size, remain;
   ctd_pkg::hex_digit_type             digit;
   logic [LENGTH_BITS-1:0]             length_inc;
   logic [WIDE_W-1:0]                  length_wide;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.in_byte;

   assign is_cr   = (b == ctd_pkg::CH_CR);
   assign is_lf   = (b == ctd_pkg::CH_LF);
   assign is_nul  = (b == ctd_pkg::CH_NUL);
   assign is_semi = (b == ctd_pkg::CH_SEMI);
   assign is_ws   = is_cr || is_lf || (b == ctd_pkg::CH_SP);
   assign digit   = ctd_pkg::hex_decode(b);

   // size line datapath and payload decision
   always_comb begin
      start_line = (phase_ff == ctd_pkg::PH_SEEK) && !is_ws && !is_nul;
      do_size    = start_line || (phase_ff == ctd_pkg::PH_SIZE);
      base_cnt   = start_line ? '0 : char_cnt_ff;
      base_stop  = start_line ? 1'b0 : hex_stop_ff;
      base_size  = start_line ? '0 : size_ff;
      collect    = do_size && (base_cnt < MAX_CHARS) && !is_cr && !is_lf &&
                   !is_semi && !is_nul;
      tail       = (do_size && !collect) || (phase_ff == ctd_pkg::PH_SKIP);
      line_end   = (tail && is_nul) ||
                   ((phase_ff == ctd_pkg::PH_EOL) && !is_cr && !is_lf);
      size_ok    = (base_size != '0) && !base_size[ctd_pkg::SIZE_W-1];
      take       = (line_end && size_ok) || (phase_ff == ctd_pkg::PH_DATA);
      remain     = base_size - ctd_pkg::SIZE_W'(1);

      char_cnt_in = base_cnt;
      hex_stop_in = base_stop;
      size_in     = base_size;
      if (collect) begin
         char_cnt_in = base_cnt + ctd_pkg::CHAR_CNT_W'(1);
         if (!base_stop) begin
            if (digit.is_hex) begin
               size_in = {base_size[ctd_pkg::SIZE_W-ctd_pkg::DIGIT_W-1:0], digit.value};
            end else begin
               hex_stop_in = 1'b1;
            end
         end
      end
      if (take) begin
         size_in = remain;
      end

      length_inc = (&length_ff) ? length_ff : length_ff + LENGTH_BITS'(1);
      length_in  = take ? length_inc : length_ff;

      if (req_chan.final_byte) begin
         char_cnt_in = '0;
         hex_stop_in = 1'b0;
         size_in     = '0;
         length_in   = '0;
      end
   end

   // phase next state
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         ctd_pkg::PH_SEEK: begin
            if (is_nul) begin
               phase_in = ctd_pkg::PH_DONE;
            end else if (!is_ws) begin
               phase_in = ctd_pkg::PH_SIZE;
            end
         end
         ctd_pkg::PH_SIZE, ctd_pkg::PH_SKIP, ctd_pkg::PH_EOL: begin
            phase_in = phase_ff;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
      if (tail) begin
         if (is_cr || is_lf) begin
            phase_in = ctd_pkg::PH_EOL;
         end else if (!is_nul) begin
            phase_in = ctd_pkg::PH_SKIP;
         end
      end
      if (line_end) begin
         phase_in = size_ok ? ctd_pkg::PH_DATA : ctd_pkg::PH_DONE;
      end
      if (take && (remain == '0)) begin
         phase_in = ctd_pkg::PH_SEEK;
      end
      if (req_chan.final_byte) begin
         phase_in = ctd_pkg::PH_SEEK;
      end
   end

   // response register contents
   always_comb begin
      length_wide   = WIDE_W'(length_in);
      if (req_chan.final_byte) begin
         // the report carries the count before the body-end clear
         length_wide = WIDE_W'(take ? length_inc : length_ff);
      end
      out_byte_in   = take ? b : '0;
      byte_valid_in = take;
      eos_in        = req_chan.final_byte;
      total_in      = length_wide[ctd_pkg::TOTAL_W-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         rsp_valid_in = take || req_chan.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ctd_pkg::PH_SEEK;
         char_cnt_ff  <= '0;
         hex_stop_ff  <= 1'b0;
         size_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            char_cnt_ff <= char_cnt_in;
            hex_stop_ff <= hex_stop_in;
            size_ff     <= size_in;
            length_ff   <= length_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_ff   <= out_byte_in;
         byte_valid_ff <= byte_valid_in;
         eos_ff        <= eos_in;
         total_ff      <= total_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_byte      = out_byte_ff;
   assign rsp_chan.byte_valid    = byte_valid_ff;
   assign rsp_chan.end_of_stream = eos_ff;
   assign rsp_chan.total_length  = total_ff;

endmodule

// ===== hw/rtl/ctd_checker.sv =====
// port-level checks for the chunked transfer decoder, bound to the top level
module ctd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_final_byte,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ctd_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic                         rsp_byte_valid,
   input logic                         rsp_end_of_stream,
   input logic [ctd_pkg::TOTAL_W-1:0]  rsp_total_length
);

   // a final byte always produces a report in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final_byte
      |=> rsp_valid && rsp_end_of_stream)
      else $error("final byte transaction without end-of-stream response");

   // every response carries a payload byte or an end report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_valid || rsp_end_of_stream)
      else $error("empty response transaction");

   // non-payload responses show a zero byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == '0)
      else $error("out_byte set without byte_valid");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable(rsp_out_byte) && $stable(rsp_total_length))
      else $error("stalled response changed");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_final_byte    (req_chan.final_byte),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_byte      (rsp_chan.out_byte),
   .rsp_byte_valid    (rsp_chan.byte_valid),
   .rsp_end_of_stream (rsp_chan.end_of_stream),
   .rsp_total_length  (rsp_chan.total_length)
);
